// ===== rtl/b2da_pkg.sv =====
// Shared types and constants for the binary to decimal ASCII converter.
// Depends on nothing; imported by binary_to_decimal_ascii.
package b2da_pkg;

   // Width of the converted value; bits of the request above it are dropped
   localparam int VALUE_WIDTH = 32;
   // Decimal digits needed for VALUE_WIDTH bits: floor(W * log10(2)) + 1
   localparam int DIGITS      = (VALUE_WIDTH * 30103) / 100000 + 1;
   localparam int BCD_WIDTH   = 4 * DIGITS;
   localparam int SHIFT_CNT_W = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;
   localparam int DIGIT_CNT_W = $clog2(DIGITS + 1);

   localparam int          CHAR_WIDTH = 6;
   localparam logic [CHAR_WIDTH-1:0] ASCII_ZERO = CHAR_WIDTH'(48);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SHIFT,
      ST_EMIT
   } b2da_state_type;

   // Double-dabble correction: add 3 to every BCD digit of 5 or more
   function automatic logic [BCD_WIDTH-1:0] bcd_adjust(input logic [BCD_WIDTH-1:0] bcd);
      logic [BCD_WIDTH-1:0] res;
      logic [3:0]           dig;
      res = bcd;
      for (int i = 0; i < DIGITS; i++) begin
         dig = bcd[4*i +: 4];
         if (dig >= 4'd5) begin
            res[4*i +: 4] = dig + 4'd3;
         end
      end
      return res;
   endfunction

endpackage

// ===== rtl/binary_to_decimal_ascii.sv =====
// Binary to decimal ASCII converter: top level and its whole datapath.
// Depends on b2da_pkg for widths, state type and the BCD correction.
//
// Converts one unsigned 32-bit request value into its decimal text, most
// significant digit first, one ASCII digit per response, leading zeros
// suppressed (zero gives a single '0'); rsp_last marks the final digit.
// One shared shift/add-3 unit runs the double-dabble conversion, one value bit
// per cycle, then a digit shifter walks the BCD register one digit per cycle,
// dropping leading zeros, but stalls while a digit waits for a busy output
// register. req_ready is high only between requests. The last digit sits in
// an output register, so the next request is taken while that digit still
// waits.
module binary_to_decimal_ascii
   import b2da_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [31:0]           req_value,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [CHAR_WIDTH-1:0] rsp_digit_char,
   output logic                  rsp_last
);

   b2da_state_type          state_ff, state_in;
   logic [VALUE_WIDTH-1:0]  value_ff, value_in;
   logic [BCD_WIDTH-1:0]    bcd_ff, bcd_in;
   logic [SHIFT_CNT_W-1:0]  shift_cnt_ff, shift_cnt_in;
   logic [DIGIT_CNT_W-1:0]  digit_cnt_ff, digit_cnt_in;
   logic                    started_ff, started_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [CHAR_WIDTH-1:0]   rsp_char_ff, rsp_char_in;
   logic                    rsp_last_ff, rsp_last_in;

   logic [BCD_WIDTH-1:0]    bcd_adj;
   logic [3:0]              top_digit;
   logic                    is_last;
   logic                    show;
   logic                    slot_free;

   assign req_ready      = (state_ff == ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_digit_char = rsp_char_ff;
   assign rsp_last       = rsp_last_ff;

   assign bcd_adj   = bcd_adjust(bcd_ff);
   assign top_digit = bcd_ff[BCD_WIDTH-1 -: 4];
   assign is_last   = (digit_cnt_ff == DIGIT_CNT_W'(1));
   assign show      = started_ff || (top_digit != 4'd0) || is_last;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   // Hold state and datapath registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      value_ff     <= value_in;
      bcd_ff       <= bcd_in;
      shift_cnt_ff <= shift_cnt_in;
      digit_cnt_ff <= digit_cnt_in;
      started_ff   <= started_in;
      rsp_char_ff  <= rsp_char_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // Sequence load, shift and digit emission
   always_comb begin
      state_in     = state_ff;
      value_in     = value_ff;
      bcd_in       = bcd_ff;
      shift_cnt_in = shift_cnt_ff;
      digit_cnt_in = digit_cnt_ff;
      started_in   = started_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;

      // Drop the held digit once taken
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               value_in     = VALUE_WIDTH'(req_value);
               bcd_in       = '0;
               shift_cnt_in = SHIFT_CNT_W'(VALUE_WIDTH - 1);
               state_in     = ST_SHIFT;
            end
         end
         ST_SHIFT: begin
            // Correct digits, then shift one value bit into the BCD register
            bcd_in   = {bcd_adj[BCD_WIDTH-2:0], value_ff[VALUE_WIDTH-1]};
            value_in = value_ff << 1;
            if (shift_cnt_ff == '0) begin
               digit_cnt_in = DIGIT_CNT_W'(DIGITS);
               started_in   = 1'b0;
               state_in     = ST_EMIT;
            end else begin
               shift_cnt_in = shift_cnt_ff - SHIFT_CNT_W'(1);
            end
         end
         ST_EMIT: begin
            // Skip leading zeros; otherwise wait for a free output slot
            if (!show || slot_free) begin
               if (show) begin
                  rsp_valid_in = 1'b1;
                  rsp_char_in  = ASCII_ZERO + CHAR_WIDTH'(top_digit);
                  rsp_last_in  = is_last;
               end
               bcd_in       = bcd_ff << 4;
               digit_cnt_in = digit_cnt_ff - DIGIT_CNT_W'(1);
               started_in   = show;
               if (is_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule
